[src/awc_pkg.sv]
package awc_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int COUNT_WIDTH = 16;
  localparam int NSYM        = 256;
  localparam int SYM_W       = 8;
  localparam int BAL_W       = 10;
  localparam int UNB_W       = 9;
  localparam int TOTAL_W     = 16;
  localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);
  localparam int RING_AW     = $clog2(MAX_PATTERN);
  localparam int QDEPTH      = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [SYM_W-1:0] sym;
  } op_t;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_PAT_WR,
    ST_RD_OLD,
    ST_WR_OLD,
    ST_WR_NEW
  } state_t;

endpackage

[src/anagram_window_counter.sv]
// Channel | Ports                        | Contents
// in      | in_tvalid/in_tready          | tuser[1:0] command, tdata[7:0] symbol
// out     | out_tvalid/out_tready        | tuser[0] window_match, tuser[1] rejected,
//         |                              | tdata[15:0] match_total
// A two-entry queue decouples input from the balance-store sequencer.
// Clear, unused, rejected and empty-pattern text requests end in fetch; pattern
// bytes add a write, text bytes a write-new, and read-old and write-old once full
// (leave and enter each read-modify-write the single-write-port balance store). Reset
// is synchronous, active low; clear zeroes balances at once via per-symbol valid
// bits. Output stall holds the sequencer; input is taken while the queue has room.
module anagram_window_counter
  import awc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_tuser,   // command
  input  logic [SYM_W-1:0]   in_tdata,   // symbol
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TOTAL_W-1:0] out_tdata,  // match_total
  output logic [1:0]         out_tuser   // window_match, rejected
);

  logic q_valid, q_pop;
  op_t  q_op;

  awc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop)
  );

  awc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[src/awc_front.sv]
module awc_front
  import awc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [1:0]       in_tuser,
  input  logic [SYM_W-1:0] in_tdata,
  output logic             q_valid,
  output op_t              q_op,
  input  logic             q_pop
);

  op_t                  q_mem_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(QDEPTH):0]   cnt_r, cnt_nxt;
  logic                 push;
  op_t                  op_in;

  // classify the incoming request
  always_comb begin
    op_in.cmd = cmd_t'(in_tuser);
    op_in.sym = in_tdata;
  end

  assign in_tready = (cnt_r != ($clog2(QDEPTH)+1)'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_op      = q_mem_r[rd_ptr_r];

  // advance pointers and count
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

[src/awc_back.sv]
module awc_back
  import awc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  op_t                q_op,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TOTAL_W-1:0] out_tdata,
  output logic [1:0]         out_tuser
);

  // balance store with per-entry valid bits, ring of window bytes
  logic signed [BAL_W-1:0] bal_mem [NSYM];
  logic [SYM_W-1:0]        ring_mem [MAX_PATTERN];
  logic [NSYM-1:0]         bal_vld_r, bal_vld_nxt;
  logic signed [BAL_W-1:0] bal_a_r, bal_b_r;
  logic [SYM_W-1:0]        ring_q_r;

  state_t                  state_r, state_nxt;
  logic [SYM_W-1:0]        sym_r, sym_nxt, old_r, old_nxt;
  logic [RING_AW-1:0]      pos_r, pos_nxt, rpos_r, rpos_nxt;
  logic                    full_r, full_nxt, started_r, started_nxt;
  logic signed [BAL_W-1:0] bal_new_r, bal_new_nxt;
  logic [UNB_W-1:0]        unb_r, unb_nxt;
  logic [PLEN_W-1:0]       plen_r, plen_nxt, fill_r, fill_nxt;
  logic [COUNT_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic                    ovld_r, ovld_nxt, omatch_r, omatch_nxt, orej_r, orej_nxt;
  logic [TOTAL_W-1:0]      ototal_r, ototal_nxt;

  logic                    rd_a_en, rd_b_en, ring_rd_en, bal_we, ring_we;
  logic [SYM_W-1:0]        rd_a_addr, rd_b_addr, bal_waddr;
  logic [RING_AW-1:0]      ring_raddr;
  logic signed [BAL_W-1:0] bal_wdata, after, base;
  logic [PLEN_W-1:0]       pos_ext, pos_inc;
  logic                    out_free;

  function automatic logic [UNB_W-1:0] unb_step(input logic [UNB_W-1:0] u,
                                                 input logic signed [BAL_W-1:0] b,
                                                 input logic signed [BAL_W-1:0] a);
    logic [UNB_W-1:0] r;
    r = u;
    if (b == '0 && a != '0) begin
      r = u + 1'b1;
    end else if (b != '0 && a == '0) begin
      r = u - 1'b1;
    end
    return r;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [COUNT_WIDTH-1:0] c);
    logic [TOTAL_W-1:0] r;
    r = TOTAL_W'(c);
    if (c > COUNT_WIDTH'({TOTAL_W{1'b1}})) begin
      r = '1;
    end
    return r;
  endfunction

  assign out_free = !ovld_r || out_tready;
  assign pos_ext  = (PLEN_W'(rpos_r) >= plen_r) ? '0 : PLEN_W'(rpos_r);
  assign pos_inc  = PLEN_W'(pos_r) + 1'b1;

  // sequence one request through the stores
  always_comb begin
    state_nxt   = state_r;
    sym_nxt     = sym_r;
    old_nxt     = old_r;
    pos_nxt     = pos_r;
    rpos_nxt    = rpos_r;
    full_nxt    = full_r;
    started_nxt = started_r;
    bal_new_nxt = bal_new_r;
    unb_nxt     = unb_r;
    plen_nxt    = plen_r;
    fill_nxt    = fill_r;
    cnt_nxt     = cnt_r;
    bal_vld_nxt = bal_vld_r;
    ovld_nxt    = ovld_r && !out_tready;
    omatch_nxt  = omatch_r;
    orej_nxt    = orej_r;
    ototal_nxt  = ototal_r;
    q_pop       = 1'b0;
    rd_a_en     = 1'b0;
    rd_a_addr   = q_op.sym;
    rd_b_en     = 1'b0;
    rd_b_addr   = ring_q_r;
    ring_rd_en  = 1'b0;
    ring_raddr  = pos_ext[RING_AW-1:0];
    bal_we      = 1'b0;
    bal_waddr   = sym_r;
    bal_wdata   = '0;
    ring_we     = 1'b0;
    after       = '0;
    base        = '0;

    unique case (state_r)
      ST_FETCH: begin
        if (q_valid && out_free) begin
          sym_nxt    = q_op.sym;
          omatch_nxt = 1'b0;
          orej_nxt   = 1'b0;
          unique case (q_op.cmd)
            CMD_CLEAR: begin
              q_pop       = 1'b1;
              bal_vld_nxt = '0;
              unb_nxt     = '0;
              plen_nxt    = '0;
              fill_nxt    = '0;
              rpos_nxt    = '0;
              cnt_nxt     = '0;
              started_nxt = 1'b0;
              ovld_nxt    = 1'b1;
              ototal_nxt  = '0;
            end
            CMD_PATTERN: begin
              if (started_r || plen_r >= PLEN_W'(MAX_PATTERN)) begin
                q_pop      = 1'b1;
                ovld_nxt   = 1'b1;
                orej_nxt   = 1'b1;
                ototal_nxt = sat_total(cnt_r);
              end else begin
                rd_a_en   = 1'b1;
                state_nxt = ST_PAT_WR;
              end
            end
            CMD_TEXT: begin
              started_nxt = 1'b1;
              if (plen_r == '0) begin
                q_pop      = 1'b1;
                ovld_nxt   = 1'b1;
                ototal_nxt = sat_total(cnt_r);
              end else begin
                rd_a_en    = 1'b1;
                ring_rd_en = 1'b1;
                pos_nxt    = pos_ext[RING_AW-1:0];
                full_nxt   = (fill_r >= plen_r);
                state_nxt  = (fill_r >= plen_r) ? ST_RD_OLD : ST_WR_NEW;
              end
            end
            CMD_NONE: begin
              q_pop      = 1'b1;
              ovld_nxt   = 1'b1;
              ototal_nxt = sat_total(cnt_r);
            end
            default: ;
          endcase
        end
      end
      ST_PAT_WR: begin
        after      = bal_a_r - 1'b1;
        bal_we     = 1'b1;
        bal_wdata  = after;
        unb_nxt    = unb_step(unb_r, bal_a_r, after);
        plen_nxt   = plen_r + 1'b1;
        q_pop      = 1'b1;
        ovld_nxt   = 1'b1;
        ototal_nxt = sat_total(cnt_r);
        state_nxt  = ST_FETCH;
      end
      ST_RD_OLD: begin
        // fetch the balance of the leaving byte
        rd_b_en     = 1'b1;
        old_nxt     = ring_q_r;
        bal_new_nxt = bal_a_r;
        state_nxt   = ST_WR_OLD;
      end
      ST_WR_OLD: begin
        after     = bal_b_r - 1'b1;
        bal_we    = 1'b1;
        bal_waddr = old_r;
        bal_wdata = after;
        unb_nxt   = unb_step(unb_r, bal_b_r, after);
        if (old_r == sym_r) begin
          bal_new_nxt = after;
        end
        state_nxt = ST_WR_NEW;
      end
      ST_WR_NEW: begin
        base      = full_r ? bal_new_r : bal_a_r;
        after     = base + 1'b1;
        bal_we    = 1'b1;
        bal_wdata = after;
        ring_we   = 1'b1;
        unb_nxt   = unb_step(unb_r, base, after);
        if (!full_r) begin
          fill_nxt = fill_r + 1'b1;
        end
        rpos_nxt = (pos_inc >= plen_r) ? '0 : pos_inc[RING_AW-1:0];
        if (fill_nxt == plen_r && unb_nxt == '0) begin
          omatch_nxt = 1'b1;
          if (cnt_r != '1) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        q_pop      = 1'b1;
        ovld_nxt   = 1'b1;
        ototal_nxt = sat_total(cnt_nxt);
        state_nxt  = ST_FETCH;
      end
      default: state_nxt = ST_FETCH;
    endcase
    if (bal_we) begin
      bal_vld_nxt[bal_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_FETCH;
      rpos_r    <= '0;
      started_r <= 1'b0;
      unb_r     <= '0;
      plen_r    <= '0;
      fill_r    <= '0;
      cnt_r     <= '0;
      bal_vld_r <= '0;
      ovld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rpos_r    <= rpos_nxt;
      started_r <= started_nxt;
      unb_r     <= unb_nxt;
      plen_r    <= plen_nxt;
      fill_r    <= fill_nxt;
      cnt_r     <= cnt_nxt;
      bal_vld_r <= bal_vld_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r     <= sym_nxt;
    old_r     <= old_nxt;
    pos_r     <= pos_nxt;
    full_r    <= full_nxt;
    bal_new_r <= bal_new_nxt;
    omatch_r  <= omatch_nxt;
    orej_r    <= orej_nxt;
    ototal_r  <= ototal_nxt;
  end

  // balance store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (bal_we) begin
      bal_mem[bal_waddr] <= bal_wdata;
    end
    if (rd_a_en) begin
      bal_a_r <= bal_vld_r[rd_a_addr] ? bal_mem[rd_a_addr] : '0;
    end
    if (rd_b_en) begin
      bal_b_r <= bal_vld_r[rd_b_addr] ? bal_mem[rd_b_addr] : '0;
    end
  end

  // window ring
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[pos_r] <= sym_r;
    end
    if (ring_rd_en) begin
      ring_q_r <= ring_mem[ring_raddr];
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = ototal_r;
  assign out_tuser  = {orej_r, omatch_r};

endmodule
